// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // decoder modes
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_WANT_BS = 3'd3,
    MODE_WANT_U  = 3'd4,
    MODE_HEX2    = 3'd5
  } mode_t;

  // result kinds as seen on the output port
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_END      = 3'd1,
    KIND_BAD_ESC  = 3'd2,
    KIND_BAD_HEX  = 3'd3,
    KIND_NO_TRAIL = 3'd4
  } kind_t;

  // one queued record: everything one input byte produces
  typedef struct packed {
    kind_t       kind;
    logic        raw;  // single byte, passed through as is
    logic [20:0] cp;   // code point, or the raw byte in the low bits
  } rec_t;

  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;

  localparam logic [15:0] LEAD_LO   = 16'hD800;
  localparam logic [15:0] LEAD_HI   = 16'hDBFF;
  localparam logic [20:0] PAIR_BASE = 21'h10000;
  localparam logic [20:0] CP_MAX1   = 21'h7F;
  localparam logic [20:0] CP_MAX2   = 21'h7FF;
  localparam logic [20:0] CP_MAX3   = 21'hFFFF;

  localparam logic [7:0]  LEAD2     = 8'hC0;
  localparam logic [7:0]  LEAD3     = 8'hE0;
  localparam logic [7:0]  LEAD4     = 8'hF0;
  localparam logic [7:0]  CONT      = 8'h80;

endpackage

`default_nettype wire

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: classifies each accepted byte and emits one record per
// byte that yields a result.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output rec_t            rec
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] held_r, held_nxt;

  logic [4:0]  hex_d;   // bit 4 set: not a hex digit
  logic [8:0]  esc_d;   // bit 8 set: not a short escape
  logic [15:0] acc_new;
  logic        is_lead;
  logic [20:0] pair_cp;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else                               v = 5'h10;
    return v;
  endfunction

  function automatic logic [8:0] short_escape(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      8'h22:   v = 9'h022;
      8'h5C:   v = 9'h05C;
      8'h2F:   v = 9'h02F;
      8'h62:   v = 9'h008;
      8'h66:   v = 9'h00C;
      8'h6E:   v = 9'h00A;
      8'h72:   v = 9'h00D;
      8'h74:   v = 9'h009;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

  assign hex_d   = hex_value(in_byte);
  assign esc_d   = short_escape(in_byte);
  assign acc_new = {acc_r[11:0], hex_d[3:0]};
  assign is_lead = (acc_new >= LEAD_LO) && (acc_new <= LEAD_HI);
  assign pair_cp = PAIR_BASE + 21'({held_r[9:0], acc_new[9:0]});

  // next state
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    if (take) begin
      // most paths fall back to normal mode with cleared state
      mode_nxt = MODE_NORMAL;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      held_nxt = '0;
      case (mode_r)
        MODE_ESC: begin
          if (in_byte == CH_U) mode_nxt = MODE_HEX;
        end
        MODE_HEX, MODE_HEX2: begin
          if (!hex_d[4]) begin
            if (cnt_r != 2'd3) begin
              mode_nxt = mode_r;
              acc_nxt  = acc_new;
              cnt_nxt  = cnt_r + 2'd1;
              held_nxt = held_r;
            end else if (mode_r == MODE_HEX && is_lead) begin
              mode_nxt = MODE_WANT_BS;
              held_nxt = acc_new;
            end
          end
        end
        MODE_WANT_BS: begin
          if (in_byte == CH_BSLASH) begin
            mode_nxt = MODE_WANT_U;
            held_nxt = held_r;
          end
        end
        MODE_WANT_U: begin
          if (in_byte == CH_U) begin
            mode_nxt = MODE_HEX2;
            held_nxt = held_r;
          end
        end
        default: begin
          if (in_byte == CH_BSLASH) mode_nxt = MODE_ESC;
        end
      endcase
    end
  end

  // record output
  always_comb begin
    push = 1'b0;
    rec  = '{kind: KIND_DATA, raw: 1'b1, cp: 21'(in_byte)};
    if (take) begin
      case (mode_r)
        MODE_ESC: begin
          if (in_byte != CH_U) begin
            push = 1'b1;
            if (esc_d[8]) rec.kind = KIND_BAD_ESC;
            else          rec.cp   = 21'(esc_d[7:0]);
          end
        end
        MODE_HEX, MODE_HEX2: begin
          if (hex_d[4]) begin
            push     = 1'b1;
            rec.kind = KIND_BAD_HEX;
          end else if (cnt_r == 2'd3) begin
            rec.raw = 1'b0;
            if (mode_r == MODE_HEX2) begin
              push   = 1'b1;
              rec.cp = pair_cp;
            end else if (!is_lead) begin
              push   = 1'b1;
              rec.cp = 21'(acc_new);
            end
          end
        end
        MODE_WANT_BS: begin
          if (in_byte != CH_BSLASH) begin
            push     = 1'b1;
            rec.kind = KIND_NO_TRAIL;
          end
        end
        MODE_WANT_U: begin
          if (in_byte != CH_U) begin
            push     = 1'b1;
            rec.kind = KIND_NO_TRAIL;
          end
        end
        default: begin
          if (in_byte == CH_QUOTE) begin
            push     = 1'b1;
            rec.kind = KIND_END;
          end else if (in_byte != CH_BSLASH) begin
            push = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      cnt_r  <= '0;
      held_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Small record queue between the decoder and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  rec_t      wdata,
  input  wire logic pop,
  output rec_t      rdata,
  output logic      empty,
  output logic      full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rec_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (AW+1)'(DEPTH));
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    case ({push, pop})
      2'b10:   count_nxt = count_r + (AW+1)'(1);
      2'b01:   count_nxt = count_r - (AW+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("serializer popped an empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (AW+1)'(1)))
    else $error("queue push lost");
`endif

endmodule

`default_nettype wire

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: turns the record at the queue head into one to four result
// transfers, UTF-8 encoding code points.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  rec_t       head,
  input  wire logic  head_valid,
  input  wire logic  out_stall,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [2:0] out_result_kind,
  output logic       out_last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_idx;
  logic       xfer;

  // index of the final byte of this record
  always_comb begin
    if (head.kind != KIND_DATA || head.raw || head.cp <= CP_MAX1) last_idx = 2'd0;
    else if (head.cp <= CP_MAX2)                                 last_idx = 2'd1;
    else if (head.cp <= CP_MAX3)                                 last_idx = 2'd2;
    else                                                         last_idx = 2'd3;
  end

  // byte selection
  always_comb begin
    out_byte = CONT | {2'b00, head.cp[5:0]};
    case (last_idx)
      2'd0: out_byte = (head.kind == KIND_DATA) ? head.cp[7:0] : 8'h00;
      2'd1: begin
        if (idx_r == 2'd0) out_byte = LEAD2 | {3'b000, head.cp[10:6]};
      end
      2'd2: begin
        if (idx_r == 2'd0)      out_byte = LEAD3 | {4'b0000, head.cp[15:12]};
        else if (idx_r == 2'd1) out_byte = CONT | {2'b00, head.cp[11:6]};
      end
      default: begin
        if (idx_r == 2'd0)      out_byte = LEAD4 | {5'b00000, head.cp[20:18]};
        else if (idx_r == 2'd1) out_byte = CONT | {2'b00, head.cp[17:12]};
        else if (idx_r == 2'd2) out_byte = CONT | {2'b00, head.cp[11:6]};
      end
    endcase
  end

  assign out_valid       = head_valid;
  assign out_result_kind = head.kind;
  assign out_last_of_run = (idx_r == last_idx);
  assign xfer            = head_valid && !out_stall;
  assign pop             = xfer && out_last_of_run;

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) idx_nxt = out_last_of_run ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

`ifndef SYNTH
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(idx_r))
    else $error("serializer advanced while stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r <= last_idx))
    else $error("serializer index past record end");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (idx_r == 2'd0))
    else $error("serializer index not cleared between records");
`endif

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8.sv
// Path: each decoded record is written into the record queue, and its result appears on out_* from the queue head.
// Throughput: one input byte per cycle while the record queue has room.
// Output: one transfer per cycle while out_stall is low; a \u code point
// gives 1 to 4 bytes; in_stall rises only when QUEUE_DEPTH records are queued.
// Reset: synchronous, active-low rst_n empties the queue and returns the
// decoder to normal mode with cleared hex and surrogate state.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper: decodes escapes and surrogate pairs and emits
// UTF-8 bytes, string ends and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input byte channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_result_kind,
  output logic            out_last_of_run
);

  logic take;       // input transfer this cycle
  logic push;       // decoder produced a record
  rec_t rec;
  rec_t head;
  logic q_empty;
  logic q_full;
  logic pop;

  // The queue count is registered, so in_stall never waits on out_stall.
  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  // front: one byte a cycle through the escape state machine while in_stall is low
  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .push    (push),
    .rec     (rec)
  );

  // record queue decoupling the decoder from the serializer
  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (rec),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // back: UTF-8 byte serializer, pops a record after its last byte
  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (!q_empty),
    .out_stall       (out_stall),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_result_kind (out_result_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
